FILE: sv/ffsa_pkg.sv
// Package for the free frame stack allocator: sizes, transfer structs,
// opcode and status codes. No dependencies.

package ffsa_pkg;

  localparam int STACK_DEPTH = 4096;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int ADDR_W      = 32;
  localparam int PAGE_SHIFT  = 12;
  localparam int FRAME_W     = ADDR_W - PAGE_SHIFT;
  localparam int STATUS_W    = 3;
  localparam int FREE_CNT_W  = 13;
  localparam int OPCODE_W    = 2;

  localparam logic [ADDR_W-1:0] LOW_RESET  = 32'h0010_0000;
  localparam logic [ADDR_W-1:0] HIGH_RESET = 32'h0100_0000;

  localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(STACK_DEPTH);

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STATUS_W-1:0] ST_LOW   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_HIGH  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_LOW_LIMIT  = 1'b0;
  localparam logic CFG_HIGH_LIMIT = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ADDR_W-1:0]   address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]     frame_address;
    logic [STATUS_W-1:0]   status;
    logic [FREE_CNT_W-1:0] free_count;
  } out_item_t;

endpackage

FILE: sv/ffsa_frame_ram.sv
// Frame stack storage: one write port, one read port, registered read data.
// Depends on ffsa_pkg for depth and frame width.

module ffsa_frame_ram
  import ffsa_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [PTR_W-1:0]   wr_addr,
  input  logic [FRAME_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [PTR_W-1:0]   rd_addr,
  output logic [FRAME_W-1:0] rd_data
);

  logic [FRAME_W-1:0] mem [STACK_DEPTH];
  logic [FRAME_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: sv/free_frame_stack_allocator_unit.sv
// Top level of the free frame stack allocator: LIFO of 4 KiB page frames.
// Depends on ffsa_pkg and ffsa_frame_ram.
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+--------------------------------
//   input    | in_valid, in_ready, in_data    | opcode + byte address
//   result   | out_valid, out_ready, out_data | frame address, status, count
//   config   | cfg_we, cfg_index, cfg_wdata   | low limit (0), high limit (1)
//
// Free, add, a rejected request, an alloc on an empty stack and the unused
// opcode are decided in the accept cycle: one transfer per cycle unless the
// result channel stalls. A successful alloc waits for the registered RAM read.
// Synchronous active-low reset empties the stack (count only, the RAM is not
// cleared) and restores the limits. A new transfer is taken when no pop is in
// flight and the result register is empty or being drained this cycle.

module free_frame_stack_allocator_unit
  import ffsa_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,

  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,

  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,

  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;
  logic [ADDR_W-1:0] low_r, high_r;

  logic              accept;
  logic [ADDR_W-1:0] aligned;
  logic              wr_en, rd_en;
  logic [PTR_W-1:0]  rd_addr;
  logic [FRAME_W-1:0] rd_data;
  logic              full;
  logic [CNT_W-1:0]  count_dec;

  assign in_ready  = !pend_r && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign aligned   = {in_data.address[ADDR_W-1:PAGE_SHIFT], PAGE_SHIFT'(0)};
  assign full      = (count_r == DEPTH_CNT);
  assign count_dec = count_r - CNT_W'(1);
  assign rd_addr   = count_dec[PTR_W-1:0];

  ffsa_frame_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[PTR_W-1:0]),
    .wr_data (aligned[ADDR_W-1:PAGE_SHIFT]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    count_nxt     = count_r;
    pend_nxt      = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    if (pend_r) begin
      // Pop data is back from the RAM: present it.
      out_valid_nxt              = 1'b1;
      out_data_nxt.frame_address = {rd_data, PAGE_SHIFT'(0)};
      out_data_nxt.status        = ST_OK;
      out_data_nxt.free_count    = FREE_CNT_W'(count_r);
    end else if (accept) begin
      out_data_nxt.frame_address = '0;
      out_data_nxt.status        = ST_OK;
      case (in_data.opcode)
        OP_ALLOC: begin
          if (count_r == '0) begin
            out_data_nxt.status = ST_EMPTY;
            out_valid_nxt       = 1'b1;
          end else begin
            // Read the top entry; its result is built once the read data is back.
            count_nxt = count_dec;
            rd_en     = 1'b1;
            pend_nxt  = 1'b1;
          end
        end
        OP_FREE: begin
          out_valid_nxt = 1'b1;
          if (in_data.address == '0 || aligned < low_r) begin
            out_data_nxt.status = ST_LOW;
          end else if (aligned >= high_r) begin
            out_data_nxt.status = ST_HIGH;
          end else if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_ADD: begin
          out_valid_nxt = 1'b1;
          if (aligned < low_r) begin
            out_data_nxt.status = ST_LOW;
          end else if (full) begin
            out_data_nxt.status = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        default: begin
          // Unused opcode: report the count, change nothing.
          out_valid_nxt = 1'b1;
        end
      endcase
      out_data_nxt.free_count = FREE_CNT_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      low_r       <= LOW_RESET;
      high_r      <= HIGH_RESET;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LOW_LIMIT:  low_r  <= cfg_wdata;
          CFG_HIGH_LIMIT: high_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: dv/free_frame_stack_allocator_unit_tb.sv
// Self-checking testbench for free_frame_stack_allocator_unit: directed and random
// alloc/free/add traffic, checked against an in-bench frame stack predictor.
// Depends on ffsa_pkg and the allocator RTL.

module free_frame_stack_allocator_unit_tb;
  import ffsa_pkg::*;

  // The package names no code for the spare opcode; the block treats it as a no-op.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_MAX = 18;

  // One queued request plus a flag that skips the sender gap (no-idle stretches).
  typedef struct packed {
    in_item_t req;
    logic     quick;
  } frame_req_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = CFG_LOW_LIMIT;
  logic [ADDR_W-1:0] cfg_wdata = '0;

  // Predictor state: the frames held, how many, and the two limits.
  logic [FRAME_W-1:0] held_frames [STACK_DEPTH];
  int                 held_count = 0;
  logic [ADDR_W-1:0]  low_bound  = LOW_RESET;
  logic [ADDR_W-1:0]  high_bound = HIGH_RESET;

  frame_req_t frame_requests [$];   // requests not yet presented
  out_item_t  pending_results [$];  // predicted results, oldest first

  frame_req_t next_req;
  logic       holding    = 1'b0;
  int         tx_gap     = 0;
  int         rx_stall   = 0;
  bit         rx_quick   = 1'b0;
  int         mismatches = 0;

  free_frame_stack_allocator_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Push a frame number if there is room; report full otherwise.
  function automatic logic [STATUS_W-1:0] push_frame(logic [ADDR_W-1:0] aligned);
    if (held_count >= STACK_DEPTH) return ST_FULL;
    held_frames[held_count] = aligned[ADDR_W-1:PAGE_SHIFT];
    held_count++;
    return ST_OK;
  endfunction

  // Apply one accepted request to the predictor state and return its result.
  function automatic out_item_t predict_frame_op(in_item_t req);
    out_item_t         res;
    logic [ADDR_W-1:0] aligned;
    res = '0;
    res.status = ST_OK;
    aligned = {req.address[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
    case (req.opcode)
      OP_ALLOC: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held_count--;
          res.frame_address = {held_frames[held_count], {PAGE_SHIFT{1'b0}}};
        end
      end
      OP_FREE: begin
        // A raw zero is always rejected as low; low is checked before high.
        if (req.address == '0 || aligned < low_bound) res.status = ST_LOW;
        else if (aligned >= high_bound) res.status = ST_HIGH;
        else res.status = push_frame(aligned);
      end
      OP_ADD: begin
        if (aligned < low_bound) res.status = ST_LOW;
        else res.status = push_frame(aligned);
      end
      default: ;
    endcase
    res.free_count = FREE_CNT_W'(held_count);
    return res;
  endfunction

  task automatic log_mismatch(string what, out_item_t want, out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected addr %h status %0d count %0d, got addr %h status %0d count %0d",
               what, want.frame_address, want.status, want.free_count,
               got.frame_address, got.status, got.free_count);
  endtask

  // Driver: on every accepted transfer predict the result, then present the
  // next request after its drawn gap. Valid drops only between items.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      holding = 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(predict_frame_op(in_data));
      if (!in_valid || in_ready) begin
        if (!holding && frame_requests.size() != 0) begin
          next_req = frame_requests.pop_front();
          holding = 1'b1;
          tx_gap = next_req.quick ? 0 : $urandom_range(0, IDLE_MAX);
        end
        if (holding && tx_gap == 0) begin
          in_valid <= 1'b1;
          in_data <= next_req.req;
          holding = 1'b0;
        end else begin
          in_valid <= 1'b0;
          if (holding) tx_gap--;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest prediction, then
  // hold ready low for a drawn stall before taking the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result with nothing pending", '0, out_data);
      end else begin
        if (out_data.frame_address !== pending_results[0].frame_address ||
            out_data.status !== pending_results[0].status ||
            out_data.free_count !== pending_results[0].free_count)
          log_mismatch("result mismatch", pending_results[0], out_data);
        void'(pending_results.pop_front());
      end
      rx_stall = rx_quick ? 0 : $urandom_range(0, IDLE_MAX);
      out_ready <= (rx_stall == 0);
    end else if (!out_ready) begin
      if (rx_stall == 0) out_ready <= 1'b1;
      else rx_stall--;
    end
  end

  // Queue a request; throttle so that stretch settings track the traffic.
  task automatic queue_item(logic [OPCODE_W-1:0] op, logic [ADDR_W-1:0] addr, bit quick);
    frame_req_t item;
    item.req.opcode = op;
    item.req.address = addr;
    item.quick = quick;
    while (frame_requests.size() >= 4) @(negedge clk);
    frame_requests.push_back(item);
  endtask

  // Wait until nothing is queued, in flight or predicted, then let the
  // pipeline settle. Sample on the falling edge to stay clear of the drivers.
  task automatic wait_idle();
    do @(negedge clk);
    while (frame_requests.size() != 0 || holding || in_valid || pending_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic idx, logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOW_LIMIT) low_bound = value;
    else high_bound = value;
  endtask

  task automatic set_limits(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    wait_idle();
    write_limit(CFG_LOW_LIMIT, lo);
    write_limit(CFG_HIGH_LIMIT, hi);
  endtask

  function automatic logic [OPCODE_W-1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return OP_ALLOC;
    if (r < 13) return OP_FREE;
    if (r < 19) return OP_ADD;
    return OP_UNUSED;
  endfunction

  // Half the draws fall inside the window; the rest are random, hug the limits or the extremes.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] delta;
    delta = ADDR_W'($urandom_range(0, 8191)) - 32'd4096;
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return '0;
      2: return '1;
      3: return low_bound + delta;
      4: return high_bound + delta;
      default: begin
        if (high_bound <= low_bound) return $urandom();
        span = high_bound - low_bound;
        return low_bound + ($urandom() % span);
      end
    endcase
  endfunction

  // Random traffic in stretches of 40; some stretches run with no idling.
  // At pause_at the sender holds off until every result has come back.
  task automatic run_mix(int count, int pause_at);
    int n;
    bit quick_run;
    quick_run = 1'b0;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) wait_idle();
      if (n % 40 == 0) begin
        quick_run = ($urandom_range(0, 3) == 0);
        rx_quick = quick_run;
      end
      queue_item(pick_opcode(), pick_address(), quick_run);
    end
    rx_quick = 1'b0;
  endtask

  // Fill the stack to the top and push a few more, which must be dropped.
  // Needs a window that accepts every nonzero address.
  task automatic fill_stack();
    int n;
    int pushes;
    wait_idle();
    rx_quick = 1'b1;
    pushes = STACK_DEPTH - held_count + 3;
    for (n = 0; n < pushes; n++)
      queue_item($urandom_range(0, 1) ? OP_FREE : OP_ADD, $urandom() | 32'h1,
                 $urandom_range(0, 15) != 0);
    rx_quick = 1'b0;
  endtask

  // Pop everything held, then two more on the empty stack.
  task automatic drain_stack();
    int n;
    int pops;
    wait_idle();
    rx_quick = 1'b1;
    pops = held_count + 2;
    for (n = 0; n < pops; n++) queue_item(OP_ALLOC, $urandom(), $urandom_range(0, 15) != 0);
    rx_quick = 1'b0;
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset limits: empty pop, spare opcode, raw-zero
    // free, limit boundaries on both sides, add ignoring the high limit.
    queue_item(OP_ALLOC,  32'h0000_0000, 1'b0);
    queue_item(OP_UNUSED, 32'h0000_0000, 1'b0);
    queue_item(OP_FREE,   32'h0000_0000, 1'b0);
    queue_item(OP_FREE,   32'h000F_FFFF, 1'b0);
    queue_item(OP_FREE,   32'h0010_0000, 1'b1);
    queue_item(OP_FREE,   32'h00FF_FFFF, 1'b1);
    queue_item(OP_FREE,   32'h0100_0000, 1'b0);
    queue_item(OP_FREE,   32'hFFFF_FFFF, 1'b0);
    queue_item(OP_ADD,    32'hFFFF_FFFF, 1'b1);
    queue_item(OP_ADD,    32'h000F_FFFF, 1'b0);
    queue_item(OP_ADD,    32'h0010_0FFF, 1'b1);
    repeat (5) queue_item(OP_ALLOC, 32'hFFFF_FFFF, 1'b1);
    queue_item(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);

    // Low limit zero: a raw zero free is still rejected, frame zero is legal.
    set_limits(32'h0000_0000, HIGH_RESET);
    queue_item(OP_FREE,  32'h0000_0000, 1'b0);
    queue_item(OP_FREE,  32'h0000_0FFF, 1'b0);
    queue_item(OP_ADD,   32'h0000_0000, 1'b1);
    queue_item(OP_ALLOC, 32'h0000_0000, 1'b1);
    queue_item(OP_ALLOC, 32'h0000_0000, 1'b0);

    // Crossed limits: the low check wins over the high check.
    set_limits(32'h8000_0000, 32'h0000_1000);
    queue_item(OP_FREE, 32'h0000_1000, 1'b0);
    queue_item(OP_FREE, 32'h9000_0000, 1'b0);

    // Random traffic at the reset limits, with one mid-run hold-off.
    set_limits(LOW_RESET, HIGH_RESET);
    run_mix(250, 120);

    set_limits(32'h0000_0000, 32'hFFFF_FFFF);
    run_mix(200, -1);

    // Full stack: fill, then check that limits are tested before fullness.
    fill_stack();
    set_limits(32'h1000_0000, 32'h2000_0000);
    queue_item(OP_ADD,  32'h0000_0100, 1'b0);
    queue_item(OP_FREE, 32'h3000_0000, 1'b0);
    queue_item(OP_ADD,  32'h1800_0000, 1'b0);
    run_mix(150, 75);
    drain_stack();

    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_mix(100, -1);
    set_limits(32'h0000_0000, 32'h0000_0000);
    run_mix(100, -1);

    // Random windows: two ordered, one drawn freely.
    repeat (2) begin
      a = $urandom();
      b = $urandom();
      if (a > b) set_limits(b, a);
      else set_limits(a, b);
      run_mix(200, -1);
    end
    set_limits($urandom(), $urandom());
    run_mix(200, -1);

    // Drain and let the block settle before the verdict.
    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
sv/ffsa_pkg.sv
sv/ffsa_frame_ram.sv
sv/free_frame_stack_allocator_unit.sv
dv/free_frame_stack_allocator_unit_tb.sv
